[sv/tcwu_pkg.sv]
// Package for the congestion window unit: transaction structs, config struct,
// state and command types and fixed constants. No dependencies.
package tcwu_pkg;

    typedef struct packed {
        logic [1:0]  func;
        logic [30:0] ack_number;
        logic [30:0] segment_seq;
        logic [15:0] segment_len;
    } in_item_t;

    typedef struct packed {
        logic [30:0] cong_window;
        logic [30:0] base_seq;
        logic [30:0] next_seq;
        logic [47:0] read_offset;
        logic        may_send;
        logic [1:0]  loss_event;
        logic        transfer_done;
    } out_item_t;

    typedef struct packed {
        logic [15:0] segment_size;
        logic [30:0] slow_start_threshold;
        logic [15:0] timeout_ms;
        logic [30:0] wrap_guard_bytes;
        logic [47:0] total_bytes;
    } cfg_t;

    typedef enum logic [1:0] {
        FUNC_ACK  = 2'd0,
        FUNC_TICK = 2'd1,
        FUNC_SENT = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        LOSS_NONE    = 2'd0,
        LOSS_TIMEOUT = 2'd1,
        LOSS_DUPACK  = 2'd2
    } loss_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_APPLY,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        REG_SEGMENT_SIZE = 3'd0,
        REG_SSTHRESH     = 3'd1,
        REG_TIMEOUT      = 3'd2,
        REG_WRAP_GUARD   = 3'd3,
        REG_TOTAL_BYTES  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic load_item;
        logic div_start;
        logic apply;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_busy;
    } status_t;

    localparam logic [30:0] CW_MAX       = 31'h7FFF_FFFF;
    localparam logic [30:0] CW_RESET     = 31'd5872;
    localparam logic [1:0]  DUP_LIMIT    = 2'd3;
    localparam logic [15:0] TICK_MAX     = 16'hFFFF;
    localparam logic [15:0] MSS_RESET    = 16'd1468;
    localparam logic [30:0] SSTH_RESET   = 31'd46976;
    localparam logic [15:0] TIMEOUT_RST  = 16'd20;
    localparam logic [30:0] GUARD_RESET  = 31'd1048576;

endpackage

[sv/tcwu_div.sv]
// Restoring divider, one quotient bit per cycle: 32-bit dividend, 31-bit divisor.
// Uses tcwu_pkg.
module tcwu_div
    import tcwu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [30:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] q_reg, q_next;
    logic [30:0] rem_reg, rem_next;
    logic [30:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[31]};
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 31'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[30:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[sv/tcwu_dp.sv]
// Datapath: window and sequence state, item latch, update logic and result register.
// Uses tcwu_pkg and tcwu_div.
module tcwu_dp
    import tcwu_pkg::*;
#(
    parameter int SEQ_BITS = 31
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  in_item_t  in_item,
    input  cmd_t      cmd,
    output status_t   status,
    input  logic      out_ready,
    output logic      out_valid,
    output out_item_t out_item
);

    localparam logic [SEQ_BITS-1:0] SEQ_TOP = '1;

    function automatic logic wrapped(input logic [SEQ_BITS-1:0] a,
                                     input logic [SEQ_BITS-1:0] b,
                                     input logic [30:0] wg);
        return (b < a) && (32'(b) <= {1'b0, wg}) &&
               ((32'(a) + {1'b0, wg}) >= 32'(SEQ_TOP));
    endfunction

    function automatic logic newer(input logic [SEQ_BITS-1:0] a,
                                   input logic [SEQ_BITS-1:0] b,
                                   input logic [30:0] wg);
        return wrapped(a, b, wg) || ((b > a) && !wrapped(b, a, wg));
    endfunction

    // item
    logic [1:0]          func_reg;
    logic [SEQ_BITS-1:0] ack_reg, sseq_reg;
    logic [15:0]         slen_reg;

    // state
    logic [SEQ_BITS-1:0] base_reg, base_next;
    logic [SEQ_BITS-1:0] nxt_reg, nxt_next;
    logic [30:0]         ws_reg, ws_next;
    logic [1:0]          dup_reg, dup_next;
    logic [15:0]         ticks_reg, ticks_next;
    logic [47:0]         acked_reg, acked_next;
    logic [1:0]          loss_reg, loss_next;

    logic        outv_reg;
    out_item_t   out_reg, out_next;

    logic        div_done;
    logic [31:0] quot;
    logic [31:0] mss_sq;

    logic        done_now, ack_newer;
    logic [31:0] ss_sum, ssth_p3, lose_fast_w;
    logic [32:0] ca_sum;
    logic [17:0] floor4;
    logic [15:0] ticks_inc;
    logic [1:0]  dup_inc;
    logic [SEQ_BITS-1:0] ack_dist, o_dist, fit_a, fit_b;
    logic [48:0] o_sum;

    assign mss_sq = cfg.segment_size * cfg.segment_size;

    tcwu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mss_sq),
        .divisor  (ws_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign done_now  = acked_reg >= cfg.total_bytes;
    assign ack_newer = newer(base_reg, ack_reg, cfg.wrap_guard_bytes);

    assign status.need_div = !done_now && (func_reg == FUNC_ACK) && ack_newer &&
                             !(ws_reg < cfg.slow_start_threshold) && (ws_reg != '0);
    assign status.div_done = div_done;
    assign status.out_busy = outv_reg && !out_ready;

    always_comb
    begin
        base_next  = base_reg;
        nxt_next   = nxt_reg;
        ws_next    = ws_reg;
        dup_next   = dup_reg;
        ticks_next = ticks_reg;
        acked_next = acked_reg;
        loss_next  = LOSS_NONE;

        floor4      = {cfg.segment_size, 2'b00};
        ssth_p3     = {1'b0, cfg.slow_start_threshold} + 32'd3;
        lose_fast_w = ssth_p3[31] ? 32'(CW_MAX) : ssth_p3;
        if (lose_fast_w < 32'(floor4))
            lose_fast_w = 32'(floor4);
        ss_sum    = {1'b0, ws_reg} + 32'(cfg.segment_size);
        ca_sum    = 33'(ws_reg) + 33'(quot);
        ticks_inc = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + 16'd1;
        dup_inc   = dup_reg + 2'd1;
        ack_dist  = ack_reg - base_reg;

        if (!done_now)
        begin
            unique case (func_reg)
                FUNC_ACK:
                begin
                    if (ack_newer)
                    begin
                        if (ws_reg < cfg.slow_start_threshold)
                            ws_next = (ss_sum < {1'b0, cfg.slow_start_threshold}) ?
                                      ss_sum[30:0] : cfg.slow_start_threshold;
                        else if (ws_reg != '0)
                            ws_next = (ca_sum > 33'(CW_MAX)) ? CW_MAX : ca_sum[30:0];
                        acked_next = acked_reg + 48'(ack_dist);
                        base_next  = ack_reg;
                        if (newer(ack_reg, nxt_reg, cfg.wrap_guard_bytes))
                            nxt_next = ack_reg;
                        dup_next   = '0;
                        ticks_next = '0;
                    end
                    else if (ack_reg == base_reg)
                    begin
                        dup_next = dup_inc;
                        if (dup_inc == DUP_LIMIT)
                        begin
                            nxt_next   = base_reg;
                            ws_next    = lose_fast_w[30:0];
                            dup_next   = '0;
                            ticks_next = '0;
                            loss_next  = LOSS_DUPACK;
                        end
                    end
                end
                FUNC_TICK:
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc > cfg.timeout_ms)
                    begin
                        nxt_next   = base_reg;
                        ws_next    = 31'(floor4);
                        dup_next   = '0;
                        ticks_next = '0;
                        loss_next  = LOSS_TIMEOUT;
                    end
                end
                FUNC_SENT:
                begin
                    if (sseq_reg == nxt_reg)
                        nxt_next = nxt_reg + SEQ_BITS'(slen_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    // result from the updated state
    always_comb
    begin
        o_dist = nxt_reg - base_reg;
        fit_a  = base_reg + SEQ_BITS'(ws_reg);
        fit_b  = nxt_reg + SEQ_BITS'(cfg.segment_size);
        o_sum  = {1'b0, acked_reg} + 49'(o_dist);
        out_next.cong_window   = ws_reg;
        out_next.base_seq      = 31'(base_reg);
        out_next.next_seq      = 31'(nxt_reg);
        out_next.read_offset   = o_sum[47:0];
        out_next.may_send      = !newer(fit_a, fit_b, cfg.wrap_guard_bytes) &&
                                 (o_sum < {1'b0, cfg.total_bytes}) && !done_now;
        out_next.loss_event    = loss_reg;
        out_next.transfer_done = done_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            nxt_reg   <= '0;
            ws_reg    <= CW_RESET;
            dup_reg   <= '0;
            ticks_reg <= '0;
            acked_reg <= '0;
            loss_reg  <= LOSS_NONE;
            outv_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                base_reg  <= base_next;
                nxt_reg   <= nxt_next;
                ws_reg    <= ws_next;
                dup_reg   <= dup_next;
                ticks_reg <= ticks_next;
                acked_reg <= acked_next;
                loss_reg  <= loss_next;
            end
            if (cmd.load_out)
                outv_reg <= 1'b1;
            else if (out_ready)
                outv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg <= in_item.func;
            ack_reg  <= in_item.ack_number[SEQ_BITS-1:0];
            sseq_reg <= in_item.segment_seq[SEQ_BITS-1:0];
            slen_reg <= in_item.segment_len;
        end
        if (cmd.load_out)
            out_reg <= out_next;
    end

    assign out_valid = outv_reg;
    assign out_item  = out_reg;

endmodule

[sv/tcwu_ctrl.sv]
// Controller FSM: sequences item load, divide, state update and result load.
// Uses tcwu_pkg.
module tcwu_ctrl
    import tcwu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    state_next = S_APPLY;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

[sv/tcp_style_congestion_window_unit.sv]
// Top level: APB register file, controller and datapath of the congestion window unit.
// Uses tcwu_pkg, tcwu_ctrl, tcwu_dp.
//
// Sender-side Reno-style window engine. Each accepted transaction gives exactly
// one result transaction. An item passes through check, state update and
// result load; when an ack grows the window in congestion avoidance, a divide
// of MSS*MSS/cwnd through a restoring divider, one quotient bit per cycle, comes
// before the update. The next item is taken once the result is in the output
// register, never before. A result waiting on out_ready holds off only the item
// after next. Registers sit at byte addresses 8*i over a 64-bit APB port; write
// them only while idle.
module tcp_style_congestion_window_unit
    import tcwu_pkg::*;
#(
    parameter int SEQ_BITS = 31
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    cfg_t     cfg_reg;
    cmd_t     cmd;
    status_t  status;
    reg_idx_t widx;

    assign widx   = reg_idx_t'(paddr[5:3]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.segment_size         <= MSS_RESET;
            cfg_reg.slow_start_threshold <= SSTH_RESET;
            cfg_reg.timeout_ms           <= TIMEOUT_RST;
            cfg_reg.wrap_guard_bytes     <= GUARD_RESET;
            cfg_reg.total_bytes          <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                REG_SEGMENT_SIZE: cfg_reg.segment_size         <= pwdata[15:0];
                REG_SSTHRESH:     cfg_reg.slow_start_threshold <= pwdata[30:0];
                REG_TIMEOUT:      cfg_reg.timeout_ms           <= pwdata[15:0];
                REG_WRAP_GUARD:   cfg_reg.wrap_guard_bytes     <= pwdata[30:0];
                REG_TOTAL_BYTES:  cfg_reg.total_bytes          <= pwdata[47:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_SEGMENT_SIZE: prdata = 64'(cfg_reg.segment_size);
            REG_SSTHRESH:     prdata = 64'(cfg_reg.slow_start_threshold);
            REG_TIMEOUT:      prdata = 64'(cfg_reg.timeout_ms);
            REG_WRAP_GUARD:   prdata = 64'(cfg_reg.wrap_guard_bytes);
            REG_TOTAL_BYTES:  prdata = 64'(cfg_reg.total_bytes);
            default:          prdata = '0;
        endcase
    end

    tcwu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tcwu_dp #(
        .SEQ_BITS (SEQ_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule
